/* design/scpr_pkg.sv */
// ----------------------------------------------------------------------------
// scpr_pkg
// Shared constants, types and helpers for the second chance page replacement
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package scpr_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int PAGE_BITS   = 16;
  localparam int PAGE_IN_W   = 16;
  localparam int CFG_W       = 7;
  localparam int SLOT_OUT_W  = 6;
  localparam int COUNT_W     = 32;
  localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [COUNT_W-1:0]   seq;
  } scpr_item_t;

  typedef struct packed {
    logic       push;
    scpr_item_t item;
  } scpr_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scpr_qstat_t;

endpackage

`default_nettype wire

/* design/second_chance_page_replacement.sv */
// ----------------------------------------------------------------------------
// second_chance_page_replacement
// Clock (second chance) page replacement unit with running hit/fault counts.
//
// Request channel: req_valid / req_stall with page_number; a beat is taken
// when req_valid is high and req_stall is low. Result channel: res_valid /
// res_stall with hit, slot, fault_count and request_count, one beat per
// request, in request order. cfg_we / cfg_wdata write the slot count; write
// it only while no request is in flight.
// Requests enter a two-entry queue. The engine takes one request at a time:
// a hit is a tag compare over the active slots and a lowest-match select; a
// fault walks the clock hand, which visits the passed slots plus the victim
// (at most slots_in_use + 1), one slot per cycle.
// Reset (rst, synchronous) empties every slot, clears reference bits, hand
// and counters, and sets the slot count to 64. While res_stall is high the
// result holds; the engine parks the next result and the queue keeps taking
// requests until it is full, then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module second_chance_page_replacement (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [scpr_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [scpr_pkg::PAGE_IN_W-1:0]    page_number,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output logic                                   hit,
  output logic [scpr_pkg::SLOT_OUT_W-1:0]        slot,
  output logic [scpr_pkg::COUNT_W-1:0]           fault_count,
  output logic [scpr_pkg::COUNT_W-1:0]           request_count
);
  import scpr_pkg::*;

  scpr_push_t  push;
  scpr_qstat_t qstat;
  scpr_item_t  head;
  logic        pop;

  scpr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .page_number (page_number),
    .qstat       (qstat),
    .push        (push)
  );

  scpr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  scpr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .qstat         (qstat),
    .head          (head),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .hit           (hit),
    .slot          (slot),
    .fault_count   (fault_count),
    .request_count (request_count)
  );

endmodule

`default_nettype wire

/* design/scpr_front.sv */
// ----------------------------------------------------------------------------
// scpr_front
// Request intake: accepts page requests, trims them to the page width and
// tags each with its running request number before queueing.
// ----------------------------------------------------------------------------
`default_nettype none

module scpr_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic [scpr_pkg::PAGE_IN_W-1:0]  page_number,
  input  wire scpr_pkg::scpr_qstat_t           qstat,
  output scpr_pkg::scpr_push_t                 push
);
  import scpr_pkg::*;

  logic [COUNT_W-1:0] seq;
  logic [COUNT_W-1:0] seq_next;
  logic               accept;

  assign req_stall = qstat.full;
  assign accept    = req_valid && !req_stall;
  assign seq_next  = seq + COUNT_W'(1);

  assign push.push      = accept;
  assign push.item.page = PAGE_BITS'(page_number);
  assign push.item.seq  = seq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (accept) begin
      seq <= seq_next;
    end
  end

endmodule

`default_nettype wire

/* design/scpr_queue.sv */
// ----------------------------------------------------------------------------
// scpr_queue
// Short FIFO between the intake and the replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

module scpr_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scpr_pkg::scpr_push_t  push,
  input  wire logic                  pop,
  output scpr_pkg::scpr_qstat_t      qstat,
  output scpr_pkg::scpr_item_t       head
);
  import scpr_pkg::*;

  scpr_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push.push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

endmodule

`default_nettype wire

/* design/scpr_back.sv */
// ----------------------------------------------------------------------------
// scpr_back
// Replacement engine: parallel tag compare, lowest match select, clock hand
// walk on faults, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scpr_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [scpr_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire scpr_pkg::scpr_qstat_t             qstat,
  input  wire scpr_pkg::scpr_item_t              head,
  output logic                                   pop,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output logic                                   hit,
  output logic [scpr_pkg::SLOT_OUT_W-1:0]        slot,
  output logic [scpr_pkg::COUNT_W-1:0]           fault_count,
  output logic [scpr_pkg::COUNT_W-1:0]           request_count
);
  import scpr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENC  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]           state;
  logic [CFG_W-1:0]     slots_cfg;
  logic [PAGE_BITS-1:0] page_store [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid_vec;
  logic [MAX_SLOTS-1:0] ref_vec;
  logic [MAX_SLOTS-1:0] match_vec;
  logic [MAX_SLOTS-1:0] match_comb;
  logic [SLOT_W-1:0]    hand;
  logic [SLOT_W-1:0]    walk;
  logic [SLOT_W-1:0]    used;
  logic                 hit_reg;
  logic [PAGE_BITS-1:0] page_reg;
  logic [COUNT_W-1:0]   seq_reg;
  logic [COUNT_W-1:0]   faults;

  logic [CNT_W-1:0]     n_act;
  logic                 any_match;
  logic [SLOT_W-1:0]    hit_idx;
  logic [SLOT_W-1:0]    hand_start;
  logic [SLOT_W-1:0]    walk_next;
  logic                 out_free;
  logic                 res_load;
  logic                 load_hit;
  logic [SLOT_W-1:0]    load_slot;

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [MAX_SLOTS-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
      if (vec[k]) begin
        idx = SLOT_W'(k);
      end
    end
    return idx;
  endfunction

  // Clamp the programmed slot count to 1..MAX_SLOTS.
  always_comb begin
    if (slots_cfg == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(slots_cfg) > 32'(MAX_SLOTS)) begin
      n_act = CNT_W'(MAX_SLOTS);
    end else begin
      n_act = CNT_W'(slots_cfg);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      match_comb[k] = valid_vec[k] && (page_store[k] == head.page) && (k < int'(n_act));
    end
  end

  assign any_match  = |match_vec;
  assign hit_idx    = lowest_set(match_vec);
  assign hand_start = (CNT_W'(hand) >= n_act) ? '0 : hand;
  assign walk_next  = ((CNT_W'(walk) + CNT_W'(1)) == n_act) ? '0 : walk + SLOT_W'(1);
  assign out_free   = !res_valid || !res_stall;
  assign pop        = (state == S_IDLE) && !qstat.empty;

  always_comb begin
    res_load  = 1'b0;
    load_hit  = hit_reg;
    load_slot = used;
    unique case (state)
      S_ENC: begin
        if (any_match && out_free) begin
          res_load  = 1'b1;
          load_hit  = 1'b1;
          load_slot = hit_idx;
        end
      end
      S_RES: begin
        res_load = out_free;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slots_cfg <= CFG_W'(MAX_SLOTS);
      valid_vec <= '0;
      ref_vec   <= '0;
      hand      <= '0;
      faults    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_cfg <= cfg_wdata;
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            match_vec <= match_comb;
            page_reg  <= head.page;
            seq_reg   <= head.seq;
            state     <= S_ENC;
          end
        end
        S_ENC: begin
          if (any_match) begin
            ref_vec[hit_idx] <= 1'b1;
            used             <= hit_idx;
            hit_reg          <= 1'b1;
            state            <= out_free ? S_IDLE : S_RES;
          end else begin
            faults  <= faults + COUNT_W'(1);
            walk    <= hand_start;
            hit_reg <= 1'b0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          // Passed slots and the victim both leave with a clear reference bit.
          ref_vec[walk] <= 1'b0;
          if (!ref_vec[walk]) begin
            page_store[walk] <= page_reg;
            valid_vec[walk]  <= 1'b1;
            used             <= walk;
            hand             <= walk_next;
            state            <= S_RES;
          end else begin
            walk <= walk_next;
          end
        end
        S_RES: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (res_load) begin
        hit           <= load_hit;
        slot          <= SLOT_OUT_W'(load_slot);
        fault_count   <= faults;
        request_count <= seq_reg;
      end
    end
  end

endmodule

`default_nettype wire

/* sim/scpr_replacement_check.sv */
// ----------------------------------------------------------------------------
// scpr_replacement_check
// Watches the request, result and slot count ports of the second chance page
// replacement block, keeps its own copy of the page slots, reference bits,
// clock hand and counters, and compares every result beat with the expected
// result for the oldest request still in flight.
// ----------------------------------------------------------------------------
module scpr_replacement_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [scpr_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  logic [scpr_pkg::PAGE_IN_W-1:0]   page_number,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  logic                             hit,
  input  logic [scpr_pkg::SLOT_OUT_W-1:0]  slot,
  input  logic [scpr_pkg::COUNT_W-1:0]     fault_count,
  input  logic [scpr_pkg::COUNT_W-1:0]     request_count,
  output int                               mismatches,
  output int                               outstanding
);
  import scpr_pkg::*;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COUNT_W-1:0]    faults;
    logic [COUNT_W-1:0]    requests;
  } page_result_t;

  logic [PAGE_BITS-1:0] page_mem [MAX_SLOTS];
  bit                   resident [MAX_SLOTS];
  bit                   second_chance [MAX_SLOTS];
  int unsigned          hand;
  logic [COUNT_W-1:0]   faults_seen;
  logic [COUNT_W-1:0]   requests_seen;
  logic [CFG_W-1:0]     slot_limit;
  page_result_t         expected_results [$];
  int                   bad_beats;

  initial begin
    mismatches = 0;
    outstanding = 0;
    bad_beats = 0;
  end

  function automatic int unsigned live_slots();
    if (slot_limit == 0) return 1;
    if (slot_limit > MAX_SLOTS) return MAX_SLOTS;
    return 32'(slot_limit);
  endfunction

  // Look up the page, then on a miss sweep the hand until a slot with a
  // clear reference bit turns up.
  function automatic page_result_t touch_or_replace(input logic [PAGE_BITS-1:0] pg);
    page_result_t r;
    int unsigned  n;
    int unsigned  h;
    bit           found;
    n = live_slots();
    found = 1'b0;
    r.slot = '0;
    requests_seen = requests_seen + 1;
    for (int k = 0; k < n; k++) begin
      if (!found && resident[k] && page_mem[k] == pg) begin
        found = 1'b1;
        r.slot = SLOT_OUT_W'(k);
        second_chance[k] = 1'b1;
      end
    end
    if (!found) begin
      faults_seen = faults_seen + 1;
      h = (hand >= n) ? 0 : hand;
      while (second_chance[h]) begin
        second_chance[h] = 1'b0;
        h = (h + 1) % n;
      end
      page_mem[h] = pg;
      resident[h] = 1'b1;
      second_chance[h] = 1'b0;
      r.slot = SLOT_OUT_W'(h);
      hand = (h + 1) % n;
    end
    r.hit = found;
    r.faults = faults_seen;
    r.requests = requests_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    if (rst) begin
      for (int k = 0; k < MAX_SLOTS; k++) begin
        resident[k] = 1'b0;
        second_chance[k] = 1'b0;
      end
      hand = 0;
      faults_seen = '0;
      requests_seen = '0;
      slot_limit = CFG_W'(MAX_SLOTS);
      expected_results.delete();
    end else begin
      if (cfg_we) slot_limit = cfg_wdata;
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected result beat: hit=%0b slot=%0d faults=%0d requests=%0d",
                     hit, slot, fault_count, request_count);
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit || slot !== want.slot || fault_count !== want.faults ||
              request_count !== want.requests) begin
            bad_beats++;
            if (bad_beats <= 10) begin
              $display("result mismatch: expected hit=%0b slot=%0d faults=%0d requests=%0d",
                       want.hit, want.slot, want.faults, want.requests);
              $display("                 got      hit=%0b slot=%0d faults=%0d requests=%0d",
                       hit, slot, fault_count, request_count);
            end
          end
        end
      end
      if (req_valid && !req_stall)
        expected_results.push_back(touch_or_replace(page_number[PAGE_BITS-1:0]));
    end
    mismatches <= bad_beats;
    outstanding <= expected_results.size();
  end

endmodule

/* sim/tb_second_chance_page_replacement.sv */
// ----------------------------------------------------------------------------
// tb_second_chance_page_replacement
// Drives page requests and slot count writes into the second chance page
// replacement block with random gaps and result stalls, and reports the
// verdict from the failure count of the result checker.
// ----------------------------------------------------------------------------
module tb_second_chance_page_replacement;
  import scpr_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  req_valid;
  logic                  req_stall;
  logic [PAGE_IN_W-1:0]  page_number;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic [COUNT_W-1:0]    fault_count;
  logic [COUNT_W-1:0]    request_count;
  int                    mismatches;
  int                    outstanding;

  bit                    calm = 1'b0;
  int                    hold_asks = 0;
  int                    hold_done = 0;
  int                    hold_left = 0;
  logic [PAGE_IN_W-1:0]  page_list [$];

  second_chance_page_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .page_number   (page_number),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .hit           (hit),
    .slot          (slot),
    .fault_count   (fault_count),
    .request_count (request_count)
  );

  scpr_replacement_check replacement_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .page_number   (page_number),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .hit           (hit),
    .slot          (slot),
    .fault_count   (fault_count),
    .request_count (request_count),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: random stalls, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      hold_done <= hold_asks;
      hold_left <= 250;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  task automatic play_pages();
    foreach (page_list[i]) begin
      while (!calm && $urandom_range(99) < 9) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
      req_valid <= 1'b1;
      page_number <= page_list[i];
      do @(posedge clk); while (req_stall);
    end
    req_valid <= 1'b0;
    page_list.delete();
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_slot_count(input logic [CFG_W-1:0] count);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly requests from a working set a bit larger than the slot count, so
  // hits and sweeps both happen; the rest are pages from the whole range.
  task automatic random_phase(input int count, input logic [CFG_W-1:0] slots,
                              input bit hold_off);
    logic [PAGE_IN_W-1:0] base;
    int                   spread;
    set_slot_count(slots);
    if (hold_off) hold_asks <= hold_asks + 1;
    base = PAGE_IN_W'($urandom);
    spread = (slots == 0) ? 2 : int'(slots) + 1 + $urandom_range(int'(slots) / 2);
    if (spread > 100) spread = 100;
    repeat (count) begin
      if ($urandom_range(99) < 75)
        page_list.push_back(base + PAGE_IN_W'($urandom_range(spread)));
      else
        page_list.push_back(PAGE_IN_W'($urandom));
    end
    play_pages();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_valid <= 1'b0;
    page_number <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill two slots, hit both, then sweep both reference bits on a fault.
    set_slot_count(2);
    page_list = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234};
    play_pages();
    // Shrink to one slot: hand past the end restarts at slot 0.
    set_slot_count(1);
    page_list = '{16'hFFFF};
    play_pages();
    // Grow back: the page now sits in two slots, the lower one must hit.
    set_slot_count(2);
    page_list = '{16'hFFFF, 16'h5555};
    play_pages();
    // Zero slot count behaves as one slot.
    set_slot_count(0);
    page_list = '{16'hAAAA, 16'hAAAA};
    play_pages();
    // Oversized slot count behaves as the full table.
    set_slot_count(7'h7F);
    page_list = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE};
    play_pages();

    random_phase(100, 64, 1'b0);
    random_phase(100, 7, 1'b1);
    calm = 1'b1;
    random_phase(100, 32, 1'b0);
    calm = 1'b0;
    random_phase(100, 0, 1'b0);
    random_phase(100, 7'h7F, 1'b0);
    random_phase(100, CFG_W'($urandom_range(64, 1)), 1'b0);

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
